>>> design/locd_pkg.sv
// Package for the lock-order cycle detector: sizes, types, controller states.
// No dependencies.
package locd_pkg;
  localparam int MutexSlots  = 16;
  localparam int ThreadSlots = 16;
  localparam int MW = $clog2(MutexSlots);
  localparam int TW = $clog2(ThreadSlots);

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_TFULL = 2'd1, ST_MFULL = 2'd2, ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TSCAN, S_MSCAN, S_DECIDE, S_HELD, S_UNLOCK,
    S_ROOT, S_STEP, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic tscan;
    logic mscan;
    logic add_thread;
    logic add_mutex;
    logic held_step;
    logic unl_step;
    logic root_step;
    logic dfs_step;
    logic set_cycle;
    logic set_status;
    status_t status;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic scan_done;
    logic t_found;
    logic m_found;
    logic t_full;
    logic m_full;
    logic list_done;
    logic roots_done;
    logic stack_empty;
    logic cycle_hit;
    logic out_free;
  } sts_t;
endpackage

>>> design/locd_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface locd_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/lock_order_cycle_detector_unit.sv
// Top level of the lock-order cycle detector: controller plus datapath.
// Depends on locd_pkg, locd_if, locd_ctrl, locd_dp.
//  channel   dir  fields
//  evt       in   action, thread_handle, mutex_address
//  res       out  cycle_found, thread_slot, mutex_slot, status
// One event at a time: a thread-table scan, a mutex-table scan, a held-list
// walk, then for a lock a DFS over the order graph from each root in turn.
// Synchronous reset clears counts, held-list valid bits and the graph.
// A result held in the output register does not block the next event's
// work; only the final load waits for the sink.
module lock_order_cycle_detector_unit (
  input logic clk,
  input logic rst,
  locd_if.sink   evt,
  locd_if.source res
);
  import locd_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic ready_i, out_valid, o_cycle;
  logic [3:0] o_tslot, o_mslot;
  logic [1:0] o_status;

  locd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(evt.valid), .in_ready(ready_i),
    .sts(sts), .cmd(cmd)
  );
  locd_dp u_dp (
    .clk(clk), .rst(rst),
    .in_action(evt.data.action), .in_handle(evt.data.thread_handle),
    .in_addr(evt.data.mutex_address), .cmd(cmd), .sts(sts),
    .out_taken(res.valid && res.ready), .out_valid(out_valid),
    .o_cycle(o_cycle), .o_tslot(o_tslot), .o_mslot(o_mslot), .o_status(o_status)
  );

  assign evt.ready = ready_i;
  assign res.valid = out_valid;
  assign res.data.cycle_found = o_cycle;
  assign res.data.thread_slot = o_tslot;
  assign res.data.mutex_slot = o_mslot;
  assign res.data.status = status_t'(o_status);
endmodule

>>> design/locd_ctrl.sv
// Controller state machine sequencing lookup, list update and cycle search.
// Depends on locd_pkg.
module locd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  locd_pkg::sts_t sts,
  output locd_pkg::cmd_t cmd
);
  import locd_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.status = ST_OK;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_TSCAN;
        end
      end
      S_TSCAN: begin
        cmd.tscan = 1'b1;
        if (sts.scan_done) state_next = S_MSCAN;
      end
      S_MSCAN: begin
        cmd.mscan = 1'b1;
        if (sts.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        if (sts.action) begin
          if (!sts.t_found || !sts.m_found) begin
            cmd.status = ST_UNKNOWN;
            state_next = S_OUT;
          end else state_next = S_UNLOCK;
        end else if (!sts.t_found && sts.t_full) begin
          cmd.status = ST_TFULL;
          state_next = S_OUT;
        end else begin
          cmd.add_thread = !sts.t_found;
          if (!sts.m_found && sts.m_full) begin
            cmd.status = ST_MFULL;
            state_next = S_OUT;
          end else begin
            cmd.add_mutex = !sts.m_found;
            state_next = S_HELD;
          end
        end
      end
      S_HELD: begin
        cmd.held_step = 1'b1;
        if (sts.list_done) state_next = S_ROOT;
      end
      S_UNLOCK: begin
        cmd.unl_step = 1'b1;
        if (sts.list_done) state_next = S_OUT;
      end
      S_ROOT: begin
        if (sts.roots_done) state_next = S_OUT;
        else begin
          cmd.root_step = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.cycle_hit) begin
          cmd.set_cycle = 1'b1;
          state_next = S_OUT;
        end else if (sts.stack_empty) state_next = S_ROOT;
        else cmd.dfs_step = 1'b1;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_out_ret: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == S_IDLE) else $error("no return to idle");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.out_free || state == S_IDLE) else $error("ready outside idle");
endmodule

>>> design/locd_dp.sv
// Datapath: slot tables, held lists (memory), order graph and DFS stack.
// Depends on locd_pkg.
module locd_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_action,
  input  logic [63:0]    in_handle,
  input  logic [63:0]    in_addr,
  input  locd_pkg::cmd_t cmd,
  output locd_pkg::sts_t sts,
  input  logic           out_taken,
  output logic           out_valid,
  output logic           o_cycle,
  output logic [3:0]     o_tslot,
  output logic [3:0]     o_mslot,
  output logic [1:0]     o_status
);
  import locd_pkg::*;
  localparam int HD = ThreadSlots * MutexSlots;
  localparam int HW = $clog2(HD);

  logic        action;
  logic [63:0] handle, addr;
  logic [63:0] ttab [ThreadSlots];
  logic [63:0] mtab [MutexSlots];
  logic [TW:0] tcount;
  logic [MW:0] mcount;
  logic [MW:0] scan;
  logic [TW-1:0] tslot;
  logic [MW-1:0] mslot;
  logic        tfound, mfound, cycle;
  status_t     status;

  // held list: memory of mutex slots, with per-entry valid in flops
  logic [MW-1:0] held_mem [HD];
  logic [HD-1:0] held_v;
  logic [MW:0]   pidx;
  logic [MW-1:0] held_rd;
  logic          lst_phase;
  logic [HW-1:0] haddr;

  logic [MutexSlots-1:0] graph [MutexSlots];
  logic [MutexSlots-1:0] visited, onpath;
  logic [MW-1:0] stk_node [MutexSlots];
  logic [MW:0]   stk_next [MutexSlots];
  logic [MW:0]   depth, root;

  logic [MW-1:0] top_v;
  logic [MW:0]   top_i;
  logic [MW-1:0] ii;
  logic          edge_set;

  assign haddr = {tslot, pidx[MW-1:0]};
  assign top_v = stk_node[depth[MW-1:0] - 1'b1];
  assign top_i = stk_next[depth[MW-1:0] - 1'b1];
  assign ii = top_i[MW-1:0];
  assign edge_set = graph[top_v][ii];

  always_comb begin
    sts = '0;
    sts.action = action;
    sts.scan_done = cmd.tscan ? (scan >= (MW+1)'(tcount)) || (ttab[scan[MW-1:0]] == handle)
                              : (scan >= mcount) || (mtab[scan[MW-1:0]] == addr);
    sts.t_found = tfound;
    sts.m_found = mfound;
    sts.t_full = tcount == (TW+1)'(ThreadSlots);
    sts.m_full = mcount == (MW+1)'(MutexSlots);
    // lock stops at the first empty place; unlock skips empty places
    if (cmd.held_step) sts.list_done = lst_phase && (pidx[MW] || !held_v[haddr]);
    else sts.list_done = lst_phase && (pidx[MW] || (held_v[haddr] && held_rd == mslot));
    sts.roots_done = root[MW];
    sts.stack_empty = depth == '0;
    sts.cycle_hit = depth != '0 && !top_i[MW] && edge_set && onpath[ii];
    sts.out_free = !out_valid || out_taken;
  end

  always_ff @(posedge clk) begin
    held_rd <= held_mem[haddr];
    if (rst) begin
      tcount <= '0; mcount <= '0; held_v <= '0;
      depth <= '0; visited <= '0; onpath <= '0;
      for (int r = 0; r < MutexSlots; r++) graph[r] <= '0;
    end else begin
      if (cmd.load) begin
        action <= in_action; handle <= in_handle; addr <= in_addr;
        scan <= '0; tfound <= 1'b0; mfound <= 1'b0; cycle <= 1'b0;
        tslot <= '0; mslot <= '0; pidx <= '0; lst_phase <= 1'b0;
        root <= '0; depth <= '0; visited <= '0; onpath <= '0;
      end
      if (cmd.tscan) begin
        if (sts.scan_done) begin
          tfound <= scan < (MW+1)'(tcount);
          tslot <= scan[TW-1:0];
          scan <= '0;
        end else scan <= scan + 1'b1;
      end
      if (cmd.mscan) begin
        if (!sts.scan_done) scan <= scan + 1'b1;
        else begin
          mfound <= scan < mcount;
          mslot <= scan[MW-1:0];
        end
      end
      if (cmd.set_status) begin
        status <= cmd.status;
        if (cmd.status == ST_TFULL) begin tslot <= '0; mslot <= '0; end
        if (cmd.status == ST_MFULL) mslot <= '0;
        if (cmd.status == ST_UNKNOWN) begin
          if (!tfound) tslot <= '0;
          if (!mfound) mslot <= '0;
        end
      end
      if (cmd.add_thread) begin
        ttab[tcount[TW-1:0]] <= handle;
        tslot <= tcount[TW-1:0];
        tcount <= tcount + 1'b1;
      end
      if (cmd.add_mutex) begin
        mtab[mcount[MW-1:0]] <= addr;
        mslot <= mcount[MW-1:0];
        mcount <= mcount + 1'b1;
      end
      if (cmd.held_step || cmd.unl_step) begin
        if (!lst_phase) lst_phase <= 1'b1;
        else if (sts.list_done) begin
          if (!pidx[MW]) begin
            if (cmd.held_step) begin
              held_v[haddr] <= 1'b1; held_mem[haddr] <= mslot;
            end else if (held_v[haddr]) held_v[haddr] <= 1'b0;
          end
        end else begin
          if (cmd.held_step) graph[held_rd][mslot] <= 1'b1;
          pidx <= pidx + 1'b1;
          lst_phase <= 1'b0;
        end
      end
      if (cmd.root_step) begin
        if (!visited[root[MW-1:0]]) begin
          visited[root[MW-1:0]] <= 1'b1;
          onpath[root[MW-1:0]] <= 1'b1;
          stk_node[0] <= root[MW-1:0];
          stk_next[0] <= '0;
          depth <= (MW+1)'(1);
        end
        root <= root + 1'b1;
      end
      if (cmd.dfs_step) begin
        if (top_i[MW]) begin
          onpath[top_v] <= 1'b0;
          depth <= depth - 1'b1;
        end else begin
          stk_next[depth[MW-1:0] - 1'b1] <= top_i + 1'b1;
          if (edge_set && !visited[ii] && !depth[MW]) begin
            visited[ii] <= 1'b1;
            onpath[ii] <= 1'b1;
            stk_node[depth[MW-1:0]] <= ii;
            stk_next[depth[MW-1:0]] <= '0;
            depth <= depth + 1'b1;
          end
        end
      end
      if (cmd.set_cycle) cycle <= 1'b1;
      if (cmd.out_load) begin
        o_cycle <= cycle;
        o_tslot <= 4'(tslot);
        o_mslot <= 4'(mslot);
        o_status <= status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_taken) out_valid <= 1'b0;
  end

  a_counts: assert property (@(posedge clk) disable iff (rst)
    tcount <= (TW+1)'(ThreadSlots) && mcount <= (MW+1)'(MutexSlots))
    else $error("table count overflow");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    depth <= (MW+1)'(MutexSlots)) else $error("stack overflow");
  a_path: assert property (@(posedge clk) disable iff (rst)
    (onpath & ~visited) == '0) else $error("on path but not visited");
endmodule

>>> tb/lock_order_cycle_detector_unit_test.sv
// Testbench for lock_order_cycle_detector_unit: directed table then random lock/unlock
// traffic; each result checked against its table entry or a behavioural lock-order graph predictor.
// Depends on locd_pkg, locd_if and the RTL of the block.
`timescale 1ns / 100ps

module lock_order_cycle_detector_unit_test;
  import locd_pkg::*;

  localparam logic ACT_LOCK   = 1'b0;
  localparam logic ACT_UNLOCK = 1'b1;
  localparam int   POOL       = 20;

  typedef struct packed {
    logic        action;
    logic [63:0] thread_handle;
    logic [63:0] mutex_address;
  } evt_t;

  typedef struct packed {
    logic          cycle_found;
    logic [TW-1:0] thread_slot;
    logic [MW-1:0] mutex_slot;
    status_t       status;
  } res_t;

  typedef struct {
    evt_t ev;
    bit   typed;
    res_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  locd_if #(.payload_t(evt_t)) evt ();
  locd_if #(.payload_t(res_t)) res ();

  lock_order_cycle_detector_unit u_top (.clk(clk), .rst(rst), .evt(evt), .res(res));

  always #2 clk = ~clk;

  // predictor state
  logic [63:0]         thr_tab [ThreadSlots];
  int                  thr_cnt;
  logic [63:0]         mtx_tab [MutexSlots];
  int                  mtx_cnt;
  bit                  held_v  [ThreadSlots][MutexSlots];
  logic [MW-1:0]       held_s  [ThreadSlots][MutexSlots];
  logic [MutexSlots-1:0] graph [MutexSlots];

  res_t expected_q [$];
  int   mismatches = 0;

  logic [63:0] thr_pool [POOL];
  logic [63:0] mtx_pool [POOL];

  function automatic bit graph_cyclic();
    logic [MutexSlots-1:0] reach [MutexSlots];
    for (int i = 0; i < MutexSlots; i++) reach[i] = graph[i];
    for (int k = 0; k < MutexSlots; k++)
      for (int i = 0; i < MutexSlots; i++)
        if (reach[i][k]) reach[i] |= reach[k];
    for (int i = 0; i < MutexSlots; i++)
      if (reach[i][i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t predict_event(evt_t ev);
    res_t r;
    int   t;
    int   m;
    r = '{cycle_found: 1'b0, thread_slot: '0, mutex_slot: '0, status: ST_OK};
    t = -1;
    m = -1;
    for (int i = 0; i < thr_cnt; i++)
      if (t < 0 && thr_tab[i] == ev.thread_handle) t = i;
    for (int i = 0; i < mtx_cnt; i++)
      if (m < 0 && mtx_tab[i] == ev.mutex_address) m = i;
    if (ev.action == ACT_LOCK) begin
      if (t < 0) begin
        if (thr_cnt >= ThreadSlots) begin
          r.status = ST_TFULL;
          return r;
        end
        t = thr_cnt;
        thr_tab[thr_cnt++] = ev.thread_handle;
      end
      r.thread_slot = TW'(t);
      if (m < 0) begin
        if (mtx_cnt >= MutexSlots) begin
          r.status = ST_MFULL;
          return r;
        end
        m = mtx_cnt;
        mtx_tab[mtx_cnt++] = ev.mutex_address;
      end
      r.mutex_slot = MW'(m);
      for (int i = 0; i < MutexSlots; i++) begin
        if (held_v[t][i]) begin
          graph[held_s[t][i]][m] = 1'b1;
        end else begin
          held_v[t][i] = 1'b1;
          held_s[t][i] = MW'(m);
          break;
        end
      end
      r.cycle_found = graph_cyclic();
    end else begin
      if (t >= 0) r.thread_slot = TW'(t);
      if (m >= 0) r.mutex_slot = MW'(m);
      if (t < 0 || m < 0) begin
        r.status = ST_UNKNOWN;
        return r;
      end
      for (int i = 0; i < MutexSlots; i++)
        if (held_v[t][i] && held_s[t][i] == MW'(m)) begin
          held_v[t][i] = 1'b0;
          held_s[t][i] = '0;
          break;
        end
    end
    return r;
  endfunction

  // sender
  int burst_left = 0;

  task automatic send_event(evt_t ev, bit typed, res_t typed_exp);
    bit   acc;
    res_t p;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        evt.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    evt.valid <= 1'b1;
    evt.data  <= ev;
    do begin
      @(negedge clk);
      acc = evt.valid && evt.ready;
      @(posedge clk);
    end while (!acc);
    burst_left--;
    p = predict_event(ev);
    expected_q.push_back(typed ? typed_exp : p);
  endtask

  task automatic send_rand(logic act, logic [63:0] th, logic [63:0] ma);
    send_event('{action: act, thread_handle: th, mutex_address: ma}, 1'b0, res_t'('0));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver: stall pattern with stall-free stretches
  logic [7:0]  rx_cnt = '0;
  logic [15:0] rx_pat = '1;
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 1'b1;
    if (rx_cnt == '0) rx_pat <= 16'($urandom);
    res.ready <= rx_cnt[7] ? 1'b1 : rx_pat[rx_cnt[3:0]];
  end

  // result checker
  always begin
    bit   acc;
    res_t got;
    res_t want;
    @(negedge clk);
    acc = res.valid && res.ready && !rst;
    got = res.data;
    @(posedge clk);
    if (acc) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.cycle_found !== want.cycle_found || got.thread_slot !== want.thread_slot ||
            got.mutex_slot !== want.mutex_slot || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    row_t        rows [$];
    logic [63:0] ones;
    int          wait_cycles;
    int          n;
    ones = '1;
    evt.valid = 1'b0;
    evt.data  = '0;
    thr_cnt = 0;
    mtx_cnt = 0;
    for (int i = 0; i < ThreadSlots; i++) begin
      thr_tab[i] = '0;
      for (int j = 0; j < MutexSlots; j++) begin
        held_v[i][j] = 1'b0;
        held_s[i][j] = '0;
      end
    end
    for (int i = 0; i < MutexSlots; i++) begin
      mtx_tab[i] = '0;
      graph[i] = '0;
    end
    for (int i = 0; i < POOL; i++) begin
      thr_pool[i] = rand64();
      mtx_pool[i] = rand64();
    end
    thr_pool[1] = ones;
    mtx_pool[1] = ones;
    thr_pool[0] = '0;
    mtx_pool[0] = '0;

    // directed: unknown on unlock, extremes, relock self edge, unlock cases
    rows.push_back('{'{ACT_UNLOCK, 64'd0, 64'd0}, 1, '{1'b0, 4'd0, 4'd0, ST_UNKNOWN}});
    rows.push_back('{'{ACT_LOCK, 64'd0, 64'd0}, 1, '{1'b0, 4'd0, 4'd0, ST_OK}});
    rows.push_back('{'{ACT_LOCK, 64'd0, ones}, 1, '{1'b0, 4'd0, 4'd1, ST_OK}});
    rows.push_back('{'{ACT_UNLOCK, 64'd0, 64'd5}, 1, '{1'b0, 4'd0, 4'd0, ST_UNKNOWN}});
    rows.push_back('{'{ACT_UNLOCK, ones, 64'd0}, 1, '{1'b0, 4'd0, 4'd0, ST_UNKNOWN}});
    rows.push_back('{'{ACT_LOCK, ones, ones}, 1, '{1'b0, 4'd1, 4'd1, ST_OK}});
    rows.push_back('{'{ACT_LOCK, ones, 64'd7}, 0, res_t'('0)});
    rows.push_back('{'{ACT_UNLOCK, ones, 64'd0}, 0, res_t'('0)});
    rows.push_back('{'{ACT_UNLOCK, 64'd0, ones}, 0, res_t'('0)});
    rows.push_back('{'{ACT_UNLOCK, 64'd0, ones}, 0, res_t'('0)});
    rows.push_back('{'{ACT_LOCK, 64'd0, 64'd7}, 0, res_t'('0)});
    rows.push_back('{'{ACT_UNLOCK, ones, 64'd7}, 0, res_t'('0)});
    rows.push_back('{'{ACT_LOCK, ones, 64'd0}, 0, res_t'('0)});
    rows.push_back('{'{ACT_LOCK, 64'd0, 64'd0}, 0, res_t'('0)});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].exp);

    // random: mostly pooled handles so tables fill and graph grows
    n = 0;
    while (n < 900) begin
      case ($urandom_range(0, 19))
        0:       send_rand(ACT_UNLOCK, rand64(), rand64());
        1:       send_rand(ACT_LOCK, rand64(), mtx_pool[$urandom_range(0, POOL - 1)]);
        2:       send_rand(ACT_LOCK, thr_pool[$urandom_range(0, POOL - 1)], rand64());
        default: send_rand($urandom_range(0, 9) < 6 ? ACT_LOCK : ACT_UNLOCK,
                           thr_pool[$urandom_range(0, POOL - 1)],
                           mtx_pool[$urandom_range(0, POOL - 1)]);
      endcase
      n++;
    end

    // overfill one thread's held list
    for (int i = 0; i < 18; i++) send_rand(ACT_LOCK, thr_pool[2], mtx_pool[i % MutexSlots]);

    evt.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    n = 0;
    while (n < 820) begin
      send_rand($urandom_range(0, 1) ? ACT_LOCK : ACT_UNLOCK,
                $urandom_range(0, 15) == 0 ? rand64() : thr_pool[$urandom_range(0, POOL - 1)],
                $urandom_range(0, 15) == 0 ? rand64() : mtx_pool[$urandom_range(0, POOL - 1)]);
      n++;
    end
    evt.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
